// File: rtl/core/rrbm_pkg.sv
// ----------------------------------------------------------------------------
// rrbm_pkg: shared types and constants of the ROM/RAM bank mapper
// Field widths, mapper type codes, address window codes and reset values.
// ----------------------------------------------------------------------------
package rrbm_pkg;

  // Field widths.
  localparam int ADDR_W  = 15;
  localparam int DATA_W  = 8;
  localparam int ROM_W   = 9;
  localparam int RAM_W   = 4;
  localparam int MTYPE_W = 2;

  // Mapper type codes, as written to the configuration register.
  typedef enum logic [MTYPE_W-1:0] {
    MAP_NONE = 2'd0,
    MAP_T1   = 2'd1,
    MAP_T3   = 2'd2,
    MAP_T5   = 2'd3
  } mapper_t;

  // Address windows, taken from address bits 14:13.
  typedef enum logic [1:0] {
    WIN_ENABLE = 2'd0,
    WIN_ROM    = 2'd1,
    WIN_RAM    = 2'd2,
    WIN_MODE   = 2'd3
  } window_t;

  // RAM enable nibble codes.
  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [3:0] RAM_DIS_KEY = 4'h0;

  // Type 3 RTC select range of the RAM bank register.
  localparam logic [DATA_W-1:0] RTC_SEL_LO  = 8'h08;
  localparam logic [DATA_W-1:0] RTC_SEL_HI  = 8'h0C;
  localparam logic [DATA_W-1:0] T3_RAM_MAX  = 8'h03;

  // Reset value of the ROM bank.
  localparam logic [ROM_W-1:0] ROM_BANK_RST = 9'd1;

endpackage

// File: rtl/core/rrbm_in_if.sv
// ----------------------------------------------------------------------------
// rrbm_in_if: CPU write request channel
// Valid/ready channel carrying one write address and data byte.
// ----------------------------------------------------------------------------
interface rrbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrbm_pkg::ADDR_W-1:0] write_address;
  logic [rrbm_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

// File: rtl/core/rrbm_out_if.sv
// ----------------------------------------------------------------------------
// rrbm_out_if: bank state result channel
// Valid/ready channel carrying the mapper state after one write.
// ----------------------------------------------------------------------------
interface rrbm_out_if;
  logic                       valid;
  logic                       ready;
  logic [rrbm_pkg::ROM_W-1:0] rom_bank_out;
  logic [rrbm_pkg::RAM_W-1:0] ram_bank_out;
  logic                       ram_enable_out;
  logic                       mode_out;
  logic                       rtc_select_out;

  modport source (output valid, output rom_bank_out, output ram_bank_out,
                  output ram_enable_out, output mode_out, output rtc_select_out,
                  input ready);
  modport sink   (input valid, input rom_bank_out, input ram_bank_out,
                  input ram_enable_out, input mode_out, input rtc_select_out,
                  output ready);
endinterface

// File: rtl/core/rom_ram_bank_mapper.sv
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper: cartridge ROM/RAM bank mapper
// Decodes CPU writes below 0x8000 into bank, enable, mode and RTC state.
// ----------------------------------------------------------------------------
// Each write request produces one result that holds the mapper state after
// that write. A request is taken into an input register, and once the result
// register is free or being emptied it updates the bank registers and loads
// the result register, so the block takes one request per cycle while the
// output does not stall; the single bank-register update per cycle sets
// that rate. The input register also acts as a skid stage, so a request
// is still taken while a finished result waits on the output. The mapper type
// is written through cfg_we/cfg_wdata and should be changed only while no
// request is in flight; changing it leaves the bank state as it is.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rrbm_pkg::MTYPE_W-1:0] cfg_wdata,
  rrbm_in_if.sink                      in_bus,
  rrbm_out_if.source                   out_bus
);

  // Configuration register.
  rrbm_pkg::mapper_t mtype_r;

  // Input register.
  logic                        in_vld_r;
  logic [rrbm_pkg::ADDR_W-1:0] addr_r;
  logic [rrbm_pkg::DATA_W-1:0] data_r;

  // Bank state.
  logic [rrbm_pkg::ROM_W-1:0] rom_r, rom_nxt;
  logic [rrbm_pkg::RAM_W-1:0] ram_r, ram_nxt;
  logic                       ram_en_r, ram_en_nxt;
  logic                       mode_r, mode_nxt;
  logic                       rtc_r, rtc_nxt;

  // Result register.
  logic                       out_vld_r;
  logic [rrbm_pkg::ROM_W-1:0] out_rom_r;
  logic [rrbm_pkg::RAM_W-1:0] out_ram_r;
  logic                       out_ram_en_r;
  logic                       out_mode_r;
  logic                       out_rtc_r;

  logic commit;
  logic in_take;

  // A request moves on when the result register is free or being emptied.
  assign commit  = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_take = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !in_vld_r || commit;

  // Mapper type register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtype_r <= rrbm_pkg::MAP_NONE;
    end else if (cfg_we) begin
      mtype_r <= rrbm_pkg::mapper_t'(cfg_wdata);
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      addr_r <= in_bus.write_address;
      data_r <= in_bus.write_data;
    end
  end

  // Next bank state for the registered request.
  always_comb begin
    rrbm_pkg::window_t          win;
    logic [4:0]                 low5;
    logic [6:0]                 bank7;
    logic                       en_touch;
    win      = rrbm_pkg::window_t'(addr_r[rrbm_pkg::ADDR_W-1 -: 2]);
    low5     = (data_r[4:0] == 5'd0) ? 5'd1 : data_r[4:0];
    bank7    = (data_r[6:0] == 7'd0) ? 7'd1 : data_r[6:0];
    en_touch = 1'b0;
    rom_nxt    = rom_r;
    ram_nxt    = ram_r;
    ram_en_nxt = ram_en_r;
    mode_nxt   = mode_r;
    rtc_nxt    = rtc_r;

    case (mtype_r)
      rrbm_pkg::MAP_T1: begin
        case (win)
          rrbm_pkg::WIN_ENABLE: en_touch = 1'b1;
          rrbm_pkg::WIN_ROM: rom_nxt = {2'b00, rom_r[6:5], low5};
          rrbm_pkg::WIN_RAM: begin
            if (!mode_r) begin
              rom_nxt = {2'b00, data_r[1:0], rom_r[4:0]};
            end else begin
              ram_nxt = {2'b00, data_r[1:0]};
            end
          end
          rrbm_pkg::WIN_MODE: begin
            if (data_r[7:1] == 7'd0) begin
              mode_nxt = data_r[0];
            end
          end
          default: ;
        endcase
      end
      rrbm_pkg::MAP_T3: begin
        case (win)
          rrbm_pkg::WIN_ENABLE: en_touch = 1'b1;
          rrbm_pkg::WIN_ROM: rom_nxt = {2'b00, bank7};
          rrbm_pkg::WIN_RAM: begin
            if (data_r <= rrbm_pkg::T3_RAM_MAX) begin
              ram_nxt = {2'b00, data_r[1:0]};
              rtc_nxt = 1'b0;
            end else if (data_r >= rrbm_pkg::RTC_SEL_LO && data_r <= rrbm_pkg::RTC_SEL_HI) begin
              rtc_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      rrbm_pkg::MAP_T5: begin
        case (win)
          rrbm_pkg::WIN_ENABLE: en_touch = 1'b1;
          rrbm_pkg::WIN_ROM: begin
            // Address bit 12 picks the low byte or the top bank bit.
            if (!addr_r[12]) begin
              rom_nxt = {rom_r[8], data_r};
            end else begin
              rom_nxt = {data_r[0], rom_r[7:0]};
            end
          end
          rrbm_pkg::WIN_RAM: ram_nxt = data_r[3:0];
          default: ;
        endcase
      end
      default: ;
    endcase

    // RAM enable key: 0xA enables, 0x0 disables, anything else is ignored.
    if (en_touch) begin
      if (data_r[3:0] == rrbm_pkg::RAM_EN_KEY) begin
        ram_en_nxt = 1'b1;
      end else if (data_r[3:0] == rrbm_pkg::RAM_DIS_KEY) begin
        ram_en_nxt = 1'b0;
      end
    end
  end

  // Bank state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r    <= rrbm_pkg::ROM_BANK_RST;
      ram_r    <= '0;
      ram_en_r <= 1'b0;
      mode_r   <= 1'b0;
      rtc_r    <= 1'b0;
    end else if (commit) begin
      rom_r    <= rom_nxt;
      ram_r    <= ram_nxt;
      ram_en_r <= ram_en_nxt;
      mode_r   <= mode_nxt;
      rtc_r    <= rtc_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_bus.ready) begin
      out_vld_r <= in_vld_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_rom_r    <= rom_nxt;
      out_ram_r    <= ram_nxt;
      out_ram_en_r <= ram_en_nxt;
      out_mode_r   <= mode_nxt;
      out_rtc_r    <= rtc_nxt;
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.rom_bank_out   = out_rom_r;
  assign out_bus.ram_bank_out   = out_ram_r;
  assign out_bus.ram_enable_out = out_ram_en_r;
  assign out_bus.mode_out       = out_mode_r;
  assign out_bus.rtc_select_out = out_rtc_r;

  // With no mapper, a request leaves the bank state untouched.
  a_none_stable: assert property (@(posedge clk) disable iff (!rst_n)
    commit && mtype_r == rrbm_pkg::MAP_NONE |=>
      $stable(rom_r) && $stable(ram_r) && $stable(ram_en_r) && $stable(mode_r) && $stable(rtc_r))
    else $error("bank state changed with no mapper selected");

  // A type 3 ROM bank write never selects bank zero.
  a_t3_rom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    commit && mtype_r == rrbm_pkg::MAP_T3 && addr_r[14:13] == rrbm_pkg::WIN_ROM |=>
      rom_r != '0)
    else $error("type 3 ROM bank write selected bank zero");

  // RTC select moves only under the type 3 mapper.
  a_rtc_t3_only: assert property (@(posedge clk) disable iff (!rst_n)
    commit && mtype_r != rrbm_pkg::MAP_T3 |=> $stable(rtc_r))
    else $error("RTC select changed outside type 3");

  // The input side stalls only when both registers are full and the output waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> in_vld_r && out_vld_r && !out_bus.ready)
    else $error("input stalled without a full pipeline");

  // A committed request always shows up as a result in the next cycle.
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_vld_r && out_rom_r == rom_r && out_ram_r == ram_r)
    else $error("committed request did not reach the result register");

endmodule
